>>> src/edhs_pkg.sv
`timescale 1ns / 1ps

package edhs_pkg;

   localparam int TABLE_LOG2_DEF = 12;
   localparam int INDEX_BITS_DEF = 16;

   // hash key layout: smaller index in the upper half
   localparam int KEY_W     = 32;
   localparam int KEY_SHIFT = 16;

   localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

   localparam int CSR_W   = 4;
   localparam int ACT_W   = 5;
   localparam int STATUS_W = 3;

   localparam logic [CSR_W-1:0] SIZE_LOG2_MIN   = 4'd4;
   localparam logic [CSR_W-1:0] SIZE_LOG2_RESET = 4'd12;

endpackage

>>> src/edhs_ram.sv
`timescale 1ns / 1ps

module edhs_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/edhs_hash.sv
`timescale 1ns / 1ps

module edhs_hash #(
   parameter int TABLE_LOG2 = edhs_pkg::TABLE_LOG2_DEF
) (
   input  logic                        clock,
   input  logic [edhs_pkg::KEY_W-1:0]  key,
   input  logic [TABLE_LOG2-1:0]       mask,
   output logic [TABLE_LOG2-1:0]       slot
);

   logic [TABLE_LOG2-1:0] prod;
   logic [TABLE_LOG2-1:0] slot_ff;

   // only the low product bits survive the mask, so multiply just those
   always_comb begin
      prod = TABLE_LOG2'(key) * TABLE_LOG2'(edhs_pkg::HASH_MULT);
   end

   always_ff @(posedge clock) begin
      slot_ff <= prod & mask;
   end

   assign slot = slot_ff;

endmodule

>>> src/edge_dedup_hash_set.sv
`timescale 1ns / 1ps

// Channel   Ports                                           Handshake
// request   req_action, req_vertex_a, req_vertex_b          start & !busy
// response  rsp_status, rsp_low_vertex, rsp_high_vertex     rsp_valid, one cycle
// config    csr_wr_data                                     csr_wr_en, any cycle
//
// Insert: S_HASH (registered hash), S_READ, then S_CHECK probing slots one
// per cycle (set by the single read port of the slot memory), until a result.
// Degenerate edge: answered from S_IDLE, busy stays low. Clear: all 2**TABLE_LOG2
// slots written empty, one slot written per cycle. Reset runs the same sweep with busy high.
// The response is a one-cycle strobe; the receiver cannot stall it.

module edge_dedup_hash_set #(
   parameter int TABLE_LOG2 = edhs_pkg::TABLE_LOG2_DEF,
   parameter int INDEX_BITS = edhs_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [INDEX_BITS-1:0]         req_vertex_a,
   input  logic [INDEX_BITS-1:0]         req_vertex_b,
   output logic                          rsp_valid,
   output logic [edhs_pkg::STATUS_W-1:0] rsp_status,
   output logic [INDEX_BITS-1:0]         rsp_low_vertex,
   output logic [INDEX_BITS-1:0]         rsp_high_vertex,
   input  logic                          csr_wr_en,
   input  logic [edhs_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int DEPTH  = 2 ** TABLE_LOG2;
   localparam int KEY_SW = 2 * INDEX_BITS;
   localparam int WORD_W = KEY_SW + 1;

   localparam logic [2:0] S_SWEEP = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;

   localparam logic [edhs_pkg::STATUS_W-1:0] ST_NEW        = 3'd0;
   localparam logic [edhs_pkg::STATUS_W-1:0] ST_PRESENT    = 3'd1;
   localparam logic [edhs_pkg::STATUS_W-1:0] ST_DEGENERATE = 3'd2;
   localparam logic [edhs_pkg::STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [edhs_pkg::STATUS_W-1:0] ST_CLEARED    = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [TABLE_LOG2-1:0]         slot_ff, slot_in;
   logic [TABLE_LOG2-1:0]         count_ff, count_in;
   logic [INDEX_BITS-1:0]         lo_ff, lo_in;
   logic [INDEX_BITS-1:0]         hi_ff, hi_in;
   logic                          clear_rsp_ff, clear_rsp_in;
   logic [edhs_pkg::CSR_W-1:0]    size_log2_ff, size_log2_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [edhs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]         rsp_low_ff, rsp_low_in;
   logic [INDEX_BITS-1:0]         rsp_high_ff, rsp_high_in;

   logic [edhs_pkg::ACT_W-1:0]    act_log2;
   logic [TABLE_LOG2-1:0]         mask;
   logic [edhs_pkg::KEY_W-1:0]    key;
   logic [TABLE_LOG2-1:0]         hash_slot;
   logic [TABLE_LOG2-1:0]         slot_next;
   logic [INDEX_BITS-1:0]         req_lo, req_hi;

   logic                          ram_we, ram_re;
   logic [TABLE_LOG2-1:0]         ram_waddr, ram_raddr;
   logic [WORD_W-1:0]             ram_wdata, ram_rdata;
   logic                          rd_valid;
   logic [KEY_SW-1:0]             rd_key;

   // clamp the register into the supported table sizes
   always_comb begin
      if (size_log2_ff < edhs_pkg::SIZE_LOG2_MIN) begin
         act_log2 = edhs_pkg::ACT_W'(edhs_pkg::SIZE_LOG2_MIN);
      end else if (edhs_pkg::ACT_W'(size_log2_ff) > edhs_pkg::ACT_W'(TABLE_LOG2)) begin
         act_log2 = edhs_pkg::ACT_W'(TABLE_LOG2);
      end else begin
         act_log2 = edhs_pkg::ACT_W'(size_log2_ff);
      end
      for (int i = 0; i < TABLE_LOG2; i++) begin
         mask[i] = edhs_pkg::ACT_W'(i) < act_log2;
      end
   end

   assign key = (edhs_pkg::KEY_W'(lo_ff) << edhs_pkg::KEY_SHIFT) | edhs_pkg::KEY_W'(hi_ff);

   edhs_hash #(
      .TABLE_LOG2 (TABLE_LOG2)
   ) u_hash (
      .clock (clock),
      .key   (key),
      .mask  (mask),
      .slot  (hash_slot)
   );

   edhs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_valid  = ram_rdata[KEY_SW];
   assign rd_key    = ram_rdata[KEY_SW-1:0];
   assign slot_next = (slot_ff + TABLE_LOG2'(1)) & mask;
   assign req_lo    = (req_vertex_a < req_vertex_b) ? req_vertex_a : req_vertex_b;
   assign req_hi    = (req_vertex_a < req_vertex_b) ? req_vertex_b : req_vertex_a;

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      clear_rsp_in  = clear_rsp_ff;
      size_log2_in  = size_log2_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = slot_ff;

      if (csr_wr_en) begin
         size_log2_in = csr_wr_data;
      end

      case (state_ff)
         S_SWEEP: begin
            // write every physical slot empty, whatever the active size
            ram_we  = 1'b1;
            slot_in = slot_ff + TABLE_LOG2'(1);
            if (&slot_ff) begin
               state_in     = S_IDLE;
               clear_rsp_in = 1'b0;
               if (clear_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_CLEARED;
                  rsp_low_in    = '0;
                  rsp_high_in   = '0;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               lo_in = req_lo;
               hi_in = req_hi;
               if (req_action) begin
                  state_in     = S_SWEEP;
                  slot_in      = '0;
                  clear_rsp_in = 1'b1;
               end else if (req_vertex_a == req_vertex_b) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_DEGENERATE;
                  rsp_low_in    = req_lo;
                  rsp_high_in   = req_hi;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            state_in = S_READ;
         end
         S_READ: begin
            ram_re    = 1'b1;
            ram_raddr = hash_slot;
            slot_in   = hash_slot;
            count_in  = '0;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            rsp_low_in  = lo_ff;
            rsp_high_in = hi_ff;
            if (!rd_valid) begin
               ram_we        = 1'b1;
               ram_wdata     = {1'b1, lo_ff, hi_ff};
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NEW;
               state_in      = S_IDLE;
            end else if (rd_key == {lo_ff, hi_ff}) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_PRESENT;
               state_in      = S_IDLE;
            end else if (count_ff == mask) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end else begin
               // advance: read the next slot while this one is compared
               ram_re    = 1'b1;
               ram_raddr = slot_next;
               slot_in   = slot_next;
               count_in  = count_ff + TABLE_LOG2'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         slot_ff      <= '0;
         count_ff     <= '0;
         clear_rsp_ff <= 1'b0;
         size_log2_ff <= edhs_pkg::SIZE_LOG2_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         clear_rsp_ff <= clear_rsp_in;
         size_log2_ff <= size_log2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_low_vertex  = rsp_low_ff;
   assign rsp_high_vertex = rsp_high_ff;

endmodule

>>> bench/edhs_tb_pkg.sv
`timescale 1ns / 1ps

package edhs_tb_pkg;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_CLEAR  = 1'b1
   } edge_action_type;

   typedef enum logic [edhs_pkg::STATUS_W-1:0] {
      EDGE_NEW        = 3'd0,
      EDGE_PRESENT    = 3'd1,
      EDGE_DEGENERATE = 3'd2,
      EDGE_FULL       = 3'd3,
      EDGE_CLEARED    = 3'd4
   } edge_status_type;

   typedef struct packed {
      edge_status_type                       status;
      logic [edhs_pkg::INDEX_BITS_DEF-1:0]   low_vertex;
      logic [edhs_pkg::INDEX_BITS_DEF-1:0]   high_vertex;
   } edge_result_type;

endpackage

>>> bench/edhs_checker.sv
`timescale 1ns / 1ps

module edhs_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_action,
   input  logic [edhs_pkg::INDEX_BITS_DEF-1:0] req_vertex_a,
   input  logic [edhs_pkg::INDEX_BITS_DEF-1:0] req_vertex_b,
   input  logic                                rsp_valid,
   input  logic [edhs_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [edhs_pkg::INDEX_BITS_DEF-1:0] rsp_low_vertex,
   input  logic [edhs_pkg::INDEX_BITS_DEF-1:0] rsp_high_vertex,
   input  logic                                csr_wr_en,
   input  logic [edhs_pkg::CSR_W-1:0]          csr_wr_data,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int SLOTS = 1 << edhs_pkg::TABLE_LOG2_DEF;

   logic [edhs_pkg::KEY_W-1:0]   slot_key [SLOTS];
   bit                           slot_valid [SLOTS];
   logic [12:0]                  occupancy;
   logic [edhs_pkg::CSR_W-1:0]   size_log2;
   edhs_tb_pkg::edge_result_type awaited_q [$];

   function automatic edhs_tb_pkg::edge_result_type dedup_edge(
      edhs_tb_pkg::edge_action_type act, logic [15:0] va, logic [15:0] vb);
      edhs_tb_pkg::edge_result_type r;
      logic [edhs_pkg::KEY_W-1:0]   key;
      logic [edhs_pkg::KEY_W-1:0]   hashed;
      logic [edhs_pkg::KEY_W-1:0]   mask;
      logic [edhs_pkg::CSR_W-1:0]   act_log2;
      int                           slot;
      int                           n;
      bit                           done;
      r.low_vertex  = (va < vb) ? va : vb;
      r.high_vertex = (va < vb) ? vb : va;
      if (act == edhs_tb_pkg::ACT_CLEAR) begin
         foreach (slot_valid[i]) slot_valid[i] = 0;
         occupancy     = '0;
         r.status      = edhs_tb_pkg::EDGE_CLEARED;
         r.low_vertex  = '0;
         r.high_vertex = '0;
      end else if (va == vb) begin
         r.status = edhs_tb_pkg::EDGE_DEGENERATE;
      end else begin
         act_log2 = size_log2;
         if (act_log2 < edhs_pkg::SIZE_LOG2_MIN) act_log2 = edhs_pkg::SIZE_LOG2_MIN;
         if (act_log2 > edhs_pkg::TABLE_LOG2_DEF) begin
            act_log2 = edhs_pkg::CSR_W'(edhs_pkg::TABLE_LOG2_DEF);
         end
         mask     = (32'd1 << act_log2) - 32'd1;
         key      = {r.low_vertex, r.high_vertex};
         hashed   = key * edhs_pkg::HASH_MULT;
         slot     = int'(hashed & mask);
         r.status = edhs_tb_pkg::EDGE_FULL;
         done     = 0;
         // walk the probe chain, wrapping inside the active slots
         for (n = 0; n <= int'(mask) && !done; n++) begin
            if (!slot_valid[slot]) begin
               slot_key[slot]   = key;
               slot_valid[slot] = 1;
               occupancy        = occupancy + 13'd1;
               r.status         = edhs_tb_pkg::EDGE_NEW;
               done             = 1;
            end else if (slot_key[slot] == key) begin
               r.status = edhs_tb_pkg::EDGE_PRESENT;
               done     = 1;
            end else begin
               slot = int'((32'(slot) + 32'd1) & mask);
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      edhs_tb_pkg::edge_result_type want;
      if (reset) begin
         awaited_q.delete();
         foreach (slot_valid[i]) slot_valid[i] = 0;
         occupancy  = '0;
         size_log2  = edhs_pkg::SIZE_LOG2_RESET;
         fail_count <= 0;
      end else begin
         // compare results first: a result never belongs to the transaction
         // accepted at the same edge
         if (rsp_valid) begin
            if (awaited_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result with nothing awaited: status %0d low %h high %h",
                           $realtime, rsp_status, rsp_low_vertex, rsp_high_vertex);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_status !== want.status || rsp_low_vertex !== want.low_vertex ||
                   rsp_high_vertex !== want.high_vertex) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch: expected status %0d low %h high %h, got %0d %h %h",
                              $realtime, want.status, want.low_vertex, want.high_vertex,
                              rsp_status, rsp_low_vertex, rsp_high_vertex);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            awaited_q.push_back(dedup_edge(edhs_tb_pkg::edge_action_type'(req_action),
                                           req_vertex_a, req_vertex_b));
         if (csr_wr_en)
            size_log2 = csr_wr_data;
      end
      pending <= awaited_q.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int VW = edhs_pkg::INDEX_BITS_DEF;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          req_action = 1'b0;
   logic [VW-1:0]                 req_vertex_a = '0;
   logic [VW-1:0]                 req_vertex_b = '0;
   logic                          csr_wr_en = 1'b0;
   logic [edhs_pkg::CSR_W-1:0]    csr_wr_data = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [edhs_pkg::STATUS_W-1:0] rsp_status;
   logic [VW-1:0]                 rsp_low_vertex;
   logic [VW-1:0]                 rsp_high_vertex;
   int                            fail_count;
   int                            pending;

   logic [2*VW-1:0] sent_edges [$];
   int              gap_odds;
   int              phase_log2 [9] = '{4, 0, 15, 7, 13, 3, 10, 5, 12};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   edge_dedup_hash_set i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_low_vertex  (rsp_low_vertex),
      .rsp_high_vertex (rsp_high_vertex),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   edhs_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_low_vertex  (rsp_low_vertex),
      .rsp_high_vertex (rsp_high_vertex),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // hold start high until the transaction is taken; the caller lowers it
   task automatic send_edge(edhs_tb_pkg::edge_action_type act, logic [VW-1:0] va,
                            logic [VW-1:0] vb);
      @(negedge clock);
      start        <= 1'b1;
      req_action   <= act;
      req_vertex_a <= va;
      req_vertex_b <= vb;
      do @(posedge clock); while (busy);
      if (act == edhs_tb_pkg::ACT_INSERT && va != vb) begin
         sent_edges.push_back({va, vb});
         if (sent_edges.size() > 128) void'(sent_edges.pop_front());
      end
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // drop start, wait for every result and for the block to go idle
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size_log2(logic [edhs_pkg::CSR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [VW-1:0] pick_vertex();
      case ($urandom_range(0, 7))
         4:       return VW'($urandom_range(0, 31));
         5:       return VW'($urandom_range(65504, 65535));
         6:       return VW'(1) << $urandom_range(0, VW - 1);
         7:       return ~(VW'(1) << $urandom_range(0, VW - 1));
         default: return VW'($urandom);
      endcase
   endfunction

   task automatic send_random_edge();
      int              pick;
      logic [VW-1:0]   va;
      logic [VW-1:0]   vb;
      logic [2*VW-1:0] old_edge;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         send_edge(edhs_tb_pkg::ACT_CLEAR, pick_vertex(), pick_vertex());
      end else if (pick < 10) begin
         va = pick_vertex();
         send_edge(edhs_tb_pkg::ACT_INSERT, va, va);
      end else if (pick < 45 && sent_edges.size() > 0) begin
         // revisit an earlier edge, in either orientation
         old_edge = sent_edges[$urandom_range(0, sent_edges.size() - 1)];
         if ($urandom_range(0, 1))
            send_edge(edhs_tb_pkg::ACT_INSERT, old_edge[VW-1:0], old_edge[2*VW-1:VW]);
         else
            send_edge(edhs_tb_pkg::ACT_INSERT, old_edge[2*VW-1:VW], old_edge[VW-1:0]);
      end else begin
         send_edge(edhs_tb_pkg::ACT_INSERT, pick_vertex(), pick_vertex());
      end
   endtask

   initial begin
      #200_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      send_edge(edhs_tb_pkg::ACT_INSERT, 16'h0000, 16'h0000);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'h0000, 16'hFFFF);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'hFFFF, 16'h0000);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'h8000, 16'h7FFF);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'h5555, 16'hAAAA);
      send_edge(edhs_tb_pkg::ACT_CLEAR, 16'h1234, 16'hFFFF);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'h0000, 16'hFFFF);

      // fill the smallest table, then overflow it
      write_size_log2(4'd4);
      for (int i = 0; i < 17; i++)
         send_edge(edhs_tb_pkg::ACT_INSERT, VW'(i), VW'(100 + i));
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'd100, 16'd0);
      send_edge(edhs_tb_pkg::ACT_INSERT, 16'd7, 16'd7);

      foreach (phase_log2[p]) begin
         write_size_log2(phase_log2[p][edhs_pkg::CSR_W-1:0]);
         gap_odds = (p % 3 == 1 || p == $size(phase_log2) - 1) ? 0 : 30;
         for (int k = 0; k < 80; k++) begin
            if ($urandom_range(0, 99) < gap_odds)
               hold_off($urandom_range(1, 18));
            if (gap_odds != 0 && $urandom_range(0, 59) == 0)
               settle();
            send_random_edge();
         end
      end

      settle();
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
src/edhs_pkg.sv
src/edhs_ram.sv
src/edhs_hash.sv
src/edge_dedup_hash_set.sv
bench/edhs_tb_pkg.sv
bench/edhs_checker.sv
bench/testbench.sv
